// ===== rtl/qrs_pkg.sv =====
package qrs_pkg;

	localparam int ROOT_WIDTH = 34;

	typedef enum logic [1:0] {
		STAT_NONE  = 2'd0,
		STAT_ONE   = 2'd1,
		STAT_TWO   = 2'd2,
		STAT_AZERO = 2'd3
	} stat_t;

endpackage

// ===== rtl/qrs_in_if.sv =====
interface qrs_in_if #(
	parameter int COEF_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// ===== rtl/qrs_out_if.sv =====
interface qrs_out_if;
	import qrs_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [1:0]                   root_status;
	logic signed [ROOT_WIDTH-1:0] root_plus;
	logic signed [ROOT_WIDTH-1:0] root_minus;

	modport source (output valid, root_status, root_plus, root_minus, input ready);
	modport sink (input valid, root_status, root_plus, root_minus, output ready);
endinterface

// ===== rtl/qrs_front.sv =====
module qrs_front #(
	parameter int W = 16,
	parameter int F = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [W-1:0]     coef_a,
	input  logic signed [W-1:0]     coef_b,
	input  logic signed [W-1:0]     coef_c,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2*W:0]            disc,
	output qrs_pkg::stat_t          stat,
	output logic [W-1:0]            amag,
	output logic                    aneg,
	output logic signed [W+F:0]     base
);
	import qrs_pkg::*;

	localparam int DW = 2 * W + 1;
	localparam int BW = W + F + 1;

	logic [W-1:0]     am, bm, cm;
	logic             rdy1, rdy2;

	logic             v_s1;
	logic [2*W-1:0]   b2_s1, ac_s1;
	logic [W-1:0]     am_s1, bm_s1;
	logic             an_s1, bn_s1, sub_s1, az_s1;

	logic [2*W+1:0]   b2x, ac4, dsum, ddif, dsel;
	logic             lt;
	logic [BW-1:0]    bsh;
	stat_t            stat_n;

	logic             v_s2;
	logic [DW-1:0]    disc_s2;
	stat_t            stat_s2;
	logic [W-1:0]     am_s2;
	logic             an_s2;
	logic [BW-1:0]    base_s2;

	assign am = coef_a[W-1] ? W'(~coef_a + 1'b1) : W'(coef_a);
	assign bm = coef_b[W-1] ? W'(~coef_b + 1'b1) : W'(coef_b);
	assign cm = coef_c[W-1] ? W'(~coef_c + 1'b1) : W'(coef_c);

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			b2_s1  <= bm * bm;
			ac_s1  <= am * cm;
			am_s1  <= am;
			bm_s1  <= bm;
			an_s1  <= coef_a[W-1];
			bn_s1  <= coef_b[W-1];
			sub_s1 <= (cm != '0) && (coef_a[W-1] == coef_c[W-1]);
			az_s1  <= (am == '0);
		end
	end

	assign b2x  = {2'b00, b2_s1};
	assign ac4  = {ac_s1, 2'b00};
	assign dsum = b2x + ac4;
	assign ddif = b2x - ac4;
	assign lt   = b2x < ac4;
	assign dsel = sub_s1 ? ddif : dsum;
	assign bsh  = BW'(bm_s1) << F;

	always_comb begin
		if (az_s1) stat_n = STAT_AZERO;
		else if (sub_s1 && lt) stat_n = STAT_NONE;
		else if (dsel == '0) stat_n = STAT_ONE;
		else stat_n = STAT_TWO;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			disc_s2 <= dsel[DW-1:0];
			stat_s2 <= stat_n;
			am_s2   <= am_s1;
			an_s2   <= an_s1;
			base_s2 <= bn_s1 ? bsh : BW'(~bsh + 1'b1);
		end
	end

	assign out_valid = v_s2;
	assign disc      = disc_s2;
	assign stat      = stat_s2;
	assign amag      = am_s2;
	assign aneg      = an_s2;
	assign base      = base_s2;
endmodule

// ===== rtl/qrs_sqrt.sv =====
module qrs_sqrt #(
	parameter int SW     = 33,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2*SW-1:0]   x,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SW-1:0]     root,
	output logic [SIDE_W-1:0] side_out
);
	logic              v_s  [0:SW];
	logic [2*SW-1:0]   x_s  [0:SW];
	logic [SW-1:0]     r_s  [0:SW];
	logic [SW+1:0]     m_s  [0:SW];
	logic [SIDE_W-1:0] sd_s [0:SW];
	logic              rdy  [1:SW+1];

	assign v_s[0]      = in_valid;
	assign x_s[0]      = x;
	assign r_s[0]      = '0;
	assign m_s[0]      = '0;
	assign sd_s[0]     = side_in;
	assign rdy[SW+1]   = out_ready;
	assign in_ready    = rdy[1];

	for (genvar k = 1; k <= SW; k++) begin : g_step
		logic [SW+3:0] pre, trial, diff;
		logic          take;

		assign pre    = {m_s[k-1], x_s[k-1][2*SW-1 -: 2]};
		assign trial  = {2'b00, r_s[k-1], 2'b01};
		assign diff   = pre - trial;
		assign take   = pre >= trial;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (rdy[k]) v_s[k] <= v_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_s[k-1]) begin
				x_s[k]  <= x_s[k-1] << 2;
				r_s[k]  <= {r_s[k-1][SW-2:0], take};
				m_s[k]  <= take ? diff[SW+1:0] : pre[SW+1:0];
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	assign out_valid = v_s[SW];
	assign root      = r_s[SW];
	assign side_out  = sd_s[SW];
endmodule

// ===== rtl/qrs_div.sv =====
module qrs_div #(
	parameter int W = 16,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W+F:0] base,
	input  logic [W+F:0]        sroot,
	input  logic [W-1:0]        amag,
	input  logic                aneg,
	input  logic [1:0]          stat_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [W+F+2:0]      quo_p,
	output logic [W+F+2:0]      quo_m,
	output logic                neg_p,
	output logic                neg_m,
	output logic [1:0]          stat_out
);
	localparam int NW = W + F + 3;
	localparam int BW = W + F + 1;
	localparam int SW = W + F + 1;

	logic [NW-1:0] bx, sx, np, nm, magp, magm;

	logic          v_s  [0:NW];
	logic [NW-1:0] dp_s [0:NW];
	logic [NW-1:0] dm_s [0:NW];
	logic [W:0]    rp_s [0:NW];
	logic [W:0]    rm_s [0:NW];
	logic [W:0]    dv_s [0:NW];
	logic          sp_s [0:NW];
	logic          sm_s [0:NW];
	logic [1:0]    st_s [0:NW];
	logic          rdy  [0:NW+1];

	assign bx   = {{(NW-BW){base[BW-1]}}, base};
	assign sx   = {{(NW-SW){1'b0}}, sroot};
	assign np   = bx + sx;
	assign nm   = bx - sx;
	assign magp = np[NW-1] ? NW'(~np + 1'b1) : np;
	assign magm = nm[NW-1] ? NW'(~nm + 1'b1) : nm;

	assign rdy[NW+1] = out_ready;
	assign rdy[0]    = !v_s[0] || rdy[1];
	assign in_ready  = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (rdy[0]) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			dp_s[0] <= magp + NW'(amag);
			dm_s[0] <= magm + NW'(amag);
			rp_s[0] <= '0;
			rm_s[0] <= '0;
			dv_s[0] <= {amag, 1'b0};
			sp_s[0] <= np[NW-1] != aneg;
			sm_s[0] <= nm[NW-1] != aneg;
			st_s[0] <= stat_in;
		end
	end

	for (genvar k = 1; k <= NW; k++) begin : g_step
		logic [W+1:0] prep, prem, dvx, difp, difm;
		logic         tp, tm;

		assign prep   = {rp_s[k-1], dp_s[k-1][NW-1]};
		assign prem   = {rm_s[k-1], dm_s[k-1][NW-1]};
		assign dvx    = {1'b0, dv_s[k-1]};
		assign difp   = prep - dvx;
		assign difm   = prem - dvx;
		assign tp     = prep >= dvx;
		assign tm     = prem >= dvx;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (rdy[k]) v_s[k] <= v_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_s[k-1]) begin
				dp_s[k] <= {dp_s[k-1][NW-2:0], tp};
				dm_s[k] <= {dm_s[k-1][NW-2:0], tm};
				rp_s[k] <= tp ? difp[W:0] : prep[W:0];
				rm_s[k] <= tm ? difm[W:0] : prem[W:0];
				dv_s[k] <= dv_s[k-1];
				sp_s[k] <= sp_s[k-1];
				sm_s[k] <= sm_s[k-1];
				st_s[k] <= st_s[k-1];
			end
		end
	end

	assign out_valid = v_s[NW];
	assign quo_p     = dp_s[NW];
	assign quo_m     = dm_s[NW];
	assign neg_p     = sp_s[NW];
	assign neg_m     = sm_s[NW];
	assign stat_out  = st_s[NW];
endmodule

// ===== rtl/quadratic_root_solver.sv =====
// Real roots of a*x^2 + b*x + c for signed integer coefficients, in signed fixed point with
// FRAC_BITS fraction bits, rounded to nearest with ties away from zero and saturated to the
// 34-bit field. One coefficient transaction is taken every cycle unless the output stalls,
// and results leave in order. The front end forms and registers the discriminant, the
// square root resolves one bit per stage over COEF_WIDTH + FRAC_BITS + 1 stages, the
// rounding divider registers the numerators and then resolves one quotient bit per stage
// over COEF_WIDTH + FRAC_BITS + 3 stages, and an output register holds the result. A zero
// a reports status 3, a negative discriminant status 0, both with zero roots.
module quadratic_root_solver #(
	parameter int COEF_WIDTH = 16,
	parameter int FRAC_BITS  = 16
) (
	input logic        clk,
	input logic        arst_n,
	qrs_in_if.sink     coef,
	qrs_out_if.source  root
);
	import qrs_pkg::*;

	localparam int W      = COEF_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int DW     = 2 * W + 1;
	localparam int BW     = W + F + 1;
	localparam int SW     = W + F + 1;
	localparam int NW     = W + F + 3;
	localparam int SIDE_W = 2 + W + 1 + BW;
	localparam int RW     = ROOT_WIDTH;
	localparam int QX     = (NW > RW + 1) ? NW : RW + 1;
	localparam logic [QX-1:0] LIM = QX'(1) << (RW - 1);

	logic              f_valid, f_ready;
	logic [DW-1:0]     f_disc;
	stat_t             f_stat;
	logic [W-1:0]      f_am;
	logic              f_an;
	logic [BW-1:0]     f_base;

	logic              s_valid, s_ready;
	logic [SW-1:0]     s_root;
	logic [SIDE_W-1:0] s_side;

	logic              d_valid, d_ready;
	logic [NW-1:0]     d_qp, d_qm;
	logic              d_np, d_nm;
	logic [1:0]        d_stat;

	logic              vld_q;
	logic [1:0]        stat_q;
	logic [RW-1:0]     rp_q, rm_q;
	logic              zero_roots;

	function automatic logic [RW-1:0] sat_root(input logic [NW-1:0] q, input logic neg);
		logic [QX-1:0] m;
		m = QX'(q);
		if (neg) begin
			if (m > LIM) m = LIM;
			return RW'(~m + 1'b1);
		end
		if (m > LIM - 1'b1) m = LIM - 1'b1;
		return RW'(m);
	endfunction

	qrs_front #(.W(W), .F(F)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coef.valid),
		.in_ready  (coef.ready),
		.coef_a    (coef.coef_a),
		.coef_b    (coef.coef_b),
		.coef_c    (coef.coef_c),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.disc      (f_disc),
		.stat      (f_stat),
		.amag      (f_am),
		.aneg      (f_an),
		.base      (f_base)
	);

	qrs_sqrt #(.SW(SW), .SIDE_W(SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.x         ((2 * SW)'(f_disc) << (2 * F)),
		.side_in   ({f_stat, f_am, f_an, f_base}),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.root      (s_root),
		.side_out  (s_side)
	);

	qrs_div #(.W(W), .F(F)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.base      (s_side[BW-1:0]),
		.sroot     (s_root),
		.amag      (s_side[BW+W:BW+1]),
		.aneg      (s_side[BW]),
		.stat_in   (s_side[SIDE_W-1:SIDE_W-2]),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.quo_p     (d_qp),
		.quo_m     (d_qm),
		.neg_p     (d_np),
		.neg_m     (d_nm),
		.stat_out  (d_stat)
	);

	assign d_ready    = !vld_q || root.ready;
	assign zero_roots = (stat_t'(d_stat) == STAT_NONE) || (stat_t'(d_stat) == STAT_AZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (d_ready) vld_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (d_ready && d_valid) begin
			stat_q <= d_stat;
			rp_q   <= zero_roots ? '0 : sat_root(d_qp, d_np);
			rm_q   <= zero_roots ? '0 : sat_root(d_qm, d_nm);
		end
	end

	assign root.valid       = vld_q;
	assign root.root_status = stat_q;
	assign root.root_plus   = rp_q;
	assign root.root_minus  = rm_q;
endmodule

// ===== rtl/qrs_checker.sv =====
module qrs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  root_status,
	input logic [33:0] root_plus,
	input logic [33:0] root_minus
);
	import qrs_pkg::*;

	ap_no_valid_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("Result transaction offered during reset.");

	ap_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_status) &&
		$stable(root_plus) && $stable(root_minus))
		else $error("Stalled result transaction changed.");

	ap_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_status == STAT_NONE || root_status == STAT_AZERO) |->
		root_plus == '0 && root_minus == '0)
		else $error("Roots not zero for a result without real roots.");

	ap_single_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_status == STAT_ONE |-> root_plus == root_minus)
		else $error("Single root reported with two different values.");
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (root.valid),
	.out_ready   (root.ready),
	.root_status (root.root_status),
	.root_plus   (root.root_plus),
	.root_minus  (root.root_minus)
);
